// ----- hdl/rtpfec_pkg.sv -----
`default_nettype none

package rtpfec_pkg;

    // Default payload capacity of the parity store, in bytes
    localparam int MAX_PAYLOAD_DEF = 2048;
    // Fixed RTP header length
    localparam int RTP_HDR_LEN = 12;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Header positions that feed the header and timestamp parities, and the position cap
    localparam logic [15:0] POS_HDR_B0  = 16'd0;
    localparam logic [15:0] POS_HDR_B1  = 16'd1;
    localparam logic [13:0] POS_TS_WORD = 14'd1;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    // Per-item fields that the back end passes through untouched
    typedef struct packed {
        logic        packet_done;
        logic [13:0] header_recovery;
        logic [31:0] timestamp_recovery;
        logic [15:0] length_recovery;
        logic [15:0] seqnum_recovery;
        logic [11:0] recovery_length;
        logic        packet_error;
    } t_info;

    localparam int INFO_W = $bits(t_info);

endpackage

`default_nettype wire

// ----- hdl/rtpfec_front.sv -----
`default_nettype none

module rtpfec_front #(
    parameter int MAX_PAYLOAD = 2048,
    parameter int AW          = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [7:0]           i_data_byte,
    input  wire                 i_start_group,
    input  wire                 i_last_byte,
    input  wire [15:0]          i_seq_number,
    output logic [AW-1:0]       o_off,
    output logic [7:0]          o_data,
    output logic                o_pvalid,
    output logic                o_xor_en,
    output rtpfec_pkg::t_info   o_info
);
    import rtpfec_pkg::*;

    localparam int          SLW  = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MaxP = 17'(MAX_PAYLOAD);

    logic [15:0]    r_pos, n_pos;
    logic [SLW-1:0] r_slen, n_slen;
    logic [13:0]    r_hdr, n_hdr;
    logic [31:0]    r_ts, n_ts;
    logic [15:0]    r_len, n_len;
    logic [15:0]    r_seq, n_seq;
    logic           r_ovf, n_ovf;

    logic [15:0]    pos;
    logic [15:0]    off_full;
    logic [15:0]    plen;
    logic [SLW-1:0] kept;
    logic           ovf_now;
    logic           err;

    // Per-byte classification and parity folding
    always_comb begin
        pos      = i_start_group ? '0 : r_pos;
        n_slen   = i_start_group ? '0 : r_slen;
        n_hdr    = i_start_group ? '0 : r_hdr;
        n_ts     = i_start_group ? '0 : r_ts;
        n_len    = i_start_group ? '0 : r_len;
        n_seq    = i_start_group ? '0 : r_seq;
        ovf_now  = i_start_group ? 1'b0 : r_ovf;
        off_full = pos - 16'(RTP_HDR_LEN);
        plen     = pos - 16'(RTP_HDR_LEN - 1);
        kept     = '0;
        o_pvalid = 1'b0;
        o_xor_en = 1'b0;
        err      = 1'b0;

        if (pos == POS_HDR_B0) begin
            n_hdr = n_hdr ^ {i_data_byte[5:0], 8'h00};
        end else if (pos == POS_HDR_B1) begin
            n_hdr = n_hdr ^ {6'b0, i_data_byte};
        end else if (pos[15:2] == POS_TS_WORD) begin
            // timestamp is big endian in bytes 4..7
            case (pos[1:0])
                2'd0:    n_ts = n_ts ^ {i_data_byte, 24'b0};
                2'd1:    n_ts = n_ts ^ {8'b0, i_data_byte, 16'b0};
                2'd2:    n_ts = n_ts ^ {16'b0, i_data_byte, 8'b0};
                default: n_ts = n_ts ^ {24'b0, i_data_byte};
            endcase
        end else if (pos >= 16'(RTP_HDR_LEN)) begin
            if ({1'b0, off_full} < MaxP) begin
                o_pvalid = 1'b1;
                o_xor_en = {1'b0, off_full} < 17'(n_slen);
            end else begin
                ovf_now = 1'b1;
            end
        end

        // end of packet: fold length and sequence number unless the packet is short
        if (i_last_byte) begin
            if (pos < 16'(RTP_HDR_LEN - 1)) begin
                err = 1'b1;
            end else begin
                n_len = n_len ^ plen;
                n_seq = n_seq ^ i_seq_number;
                kept  = ({1'b0, plen} > MaxP) ? SLW'(MAX_PAYLOAD) : SLW'(plen);
                if (kept > n_slen) begin
                    n_slen = kept;
                end
                err = ovf_now;
            end
            n_pos = '0;
            n_ovf = 1'b0;
        end else begin
            n_pos = (pos == POS_MAX) ? pos : pos + 16'd1;
            n_ovf = ovf_now;
        end
    end

    // Item handed to the queue
    always_comb begin
        o_off                     = off_full[AW-1:0];
        o_data                    = i_data_byte;
        o_info.packet_done        = i_last_byte;
        o_info.header_recovery    = n_hdr;
        o_info.timestamp_recovery = n_ts;
        o_info.length_recovery    = n_len;
        o_info.seqnum_recovery    = n_seq;
        o_info.recovery_length    = 12'(n_slen);
        o_info.packet_error       = err;
    end

    // Group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_slen <= '0;
            r_hdr  <= '0;
            r_ts   <= '0;
            r_len  <= '0;
            r_seq  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_slen <= n_slen;
            r_hdr  <= n_hdr;
            r_ts   <= n_ts;
            r_len  <= n_len;
            r_seq  <= n_seq;
            r_ovf  <= n_ovf;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_pos == '0 && !r_ovf)
        else $error("byte position not cleared after last byte");
    a_slen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        17'(r_slen) <= MaxP)
        else $error("stored length above capacity");
    a_err_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_info.packet_error |-> i_last_byte)
        else $error("packet error flagged on a byte that is not last");
`endif

endmodule

`default_nettype wire

// ----- hdl/rtpfec_queue.sv -----
`default_nettype none

module rtpfec_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  wire [W-1:0]  i_wdata,
    output logic         o_full,
    output logic         o_valid,
    input  wire          i_pop,
    output logic [W-1:0] o_rdata
);
    import rtpfec_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_rdata = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- hdl/rtpfec_back.sv -----
`default_nettype none

module rtpfec_back #(
    parameter int MAX_PAYLOAD = 2048,
    parameter int AW          = 11
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  wire [AW-1:0]        i_q_off,
    input  wire [7:0]           i_q_data,
    input  wire                 i_q_pvalid,
    input  wire                 i_q_xor_en,
    input  rtpfec_pkg::t_info   i_q_info,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [10:0]         o_payload_offset,
    output logic [7:0]          o_recovery_byte,
    output logic                o_payload_valid,
    output rtpfec_pkg::t_info   o_info
);
    import rtpfec_pkg::*;

    logic [7:0]    r_store [MAX_PAYLOAD];
    logic [7:0]    r_rd;

    logic          r_b_valid;
    logic [AW-1:0] r_b_off;
    logic [7:0]    r_b_data;
    logic          r_b_pvalid;
    logic          r_b_xor;
    t_info         r_b_info;

    logic          r_o_valid;
    logic [10:0]   r_o_off;
    logic [7:0]    r_o_byte;
    logic          r_o_pvalid;
    t_info         r_o_info;

    logic          out_free;
    logic          b_adv;
    logic [7:0]    b_byte;

    // Pipeline advance
    assign out_free = !r_o_valid || !i_stall;
    assign b_adv    = r_b_valid && out_free;
    assign o_q_pop  = i_q_valid && (!r_b_valid || b_adv);
    assign b_byte   = r_b_xor ? (r_rd ^ r_b_data) : r_b_data;

    // Parity store: read on pop, write back as the item leaves the stage.
    // A pop of the offset being written back in the same cycle takes the new byte.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (b_adv && r_b_pvalid && (r_b_off == i_q_off)) begin
                r_rd <= b_byte;
            end else begin
                r_rd <= r_store[i_q_off];
            end
        end
        if (b_adv && r_b_pvalid) begin
            r_store[r_b_off] <= b_byte;
        end
    end

    // Update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_off    <= i_q_off;
            r_b_data   <= i_q_data;
            r_b_pvalid <= i_q_pvalid;
            r_b_xor    <= i_q_xor_en;
            r_b_info   <= i_q_info;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_off    <= r_b_pvalid ? 11'(r_b_off) : '0;
            r_o_byte   <= r_b_pvalid ? b_byte : '0;
            r_o_pvalid <= r_b_pvalid;
            r_o_info   <= r_b_info;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_payload_offset = r_o_off;
    assign o_recovery_byte  = r_o_byte;
    assign o_payload_valid  = r_o_pvalid;
    assign o_info           = r_o_info;

`ifndef ASSERT_OFF
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !b_adv |=> r_b_valid && $stable(r_b_off) && $stable(r_rd))
        else $error("update stage lost its item while blocked");
    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !out_free |-> !o_q_pop)
        else $error("pop while update stage blocked");
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_pvalid |-> 32'(r_b_off) < 32'(MAX_PAYLOAD))
        else $error("payload offset beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- hdl/rtp_xor_fec_parity_accumulator.sv -----
`default_nettype none

// RTP XOR parity accumulator (RFC 2733 style FEC). Feed one packet byte per
// item, header first; raise i_start_group on byte 0 of the packet that opens
// a group and i_last_byte on each packet's final byte, with i_seq_number
// valid on that byte. Every item yields one result: payload bytes report the
// updated parity byte and its offset, and all items report the current
// header, timestamp, length and sequence parities and the group's longest
// payload length. The block takes one item per clock unless the queue is full,
// which i_stall on the output can cause. Results pass from the queue to the
// store read, then through the read-modify-write stage into the output register.
// The rate is set by the parity store's read-modify-write, which reads an
// offset on pop, writing it back as the item leaves. The store needs no clearing
// pass after reset: a payload byte beyond the group's stored length is written
// as is, so only written entries are ever XORed. A 4-entry queue between the
// header front end and the store back end lets each side stall on its own.
module rtp_xor_fec_parity_accumulator #(
    parameter int MAX_PAYLOAD = rtpfec_pkg::MAX_PAYLOAD_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [7:0]   i_data_byte,
    input  wire         i_start_group,
    input  wire         i_last_byte,
    input  wire [15:0]  i_seq_number,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [10:0] o_payload_offset,
    output logic [7:0]  o_recovery_byte,
    output logic        o_payload_valid,
    output logic        o_packet_done,
    output logic [13:0] o_header_recovery,
    output logic [31:0] o_timestamp_recovery,
    output logic [15:0] o_length_recovery,
    output logic [15:0] o_seqnum_recovery,
    output logic [11:0] o_recovery_length,
    output logic        o_packet_error
);
    import rtpfec_pkg::*;

    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int QW = AW + 8 + 1 + 1 + INFO_W;

    logic          accept;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    logic [AW-1:0] f_off;
    logic [7:0]    f_data;
    logic          f_pvalid;
    logic          f_xor_en;
    t_info         f_info;

    logic [AW-1:0] b_off;
    logic [7:0]    b_data;
    logic          b_pvalid;
    logic          b_xor_en;
    t_info         b_info;
    t_info         o_info;

    // Input handshake
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    rtpfec_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_start_group (i_start_group),
        .i_last_byte   (i_last_byte),
        .i_seq_number  (i_seq_number),
        .o_off         (f_off),
        .o_data        (f_data),
        .o_pvalid      (f_pvalid),
        .o_xor_en      (f_xor_en),
        .o_info        (f_info)
    );

    assign q_wdata = {f_off, f_data, f_pvalid, f_xor_en, f_info};

    rtpfec_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    assign {b_off, b_data, b_pvalid, b_xor_en, b_info} = q_rdata;

    rtpfec_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_off          (b_off),
        .i_q_data         (b_data),
        .i_q_pvalid       (b_pvalid),
        .i_q_xor_en       (b_xor_en),
        .i_q_info         (b_info),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_offset (o_payload_offset),
        .o_recovery_byte  (o_recovery_byte),
        .o_payload_valid  (o_payload_valid),
        .o_info           (o_info)
    );

    // Result fields
    assign o_packet_done        = o_info.packet_done;
    assign o_header_recovery    = o_info.header_recovery;
    assign o_timestamp_recovery = o_info.timestamp_recovery;
    assign o_length_recovery    = o_info.length_recovery;
    assign o_seqnum_recovery    = o_info.seqnum_recovery;
    assign o_recovery_length    = o_info.recovery_length;
    assign o_packet_error       = o_info.packet_error;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import rtpfec_pkg::*;

    localparam int CAPACITY     = MAX_PAYLOAD_DEF;
    localparam int TS_FIRST     = 4;
    localparam int TS_LAST      = 7;
    localparam int RANDOM_ITEMS = 630;
    localparam int PHASE_LEN    = 150;
    localparam int DRAIN_WAIT   = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // one packet byte as handed to the block
    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        last;
        logic [15:0] seq;
        logic        hold;    // wait until every result is back before sending
    } t_byte_item;

    typedef struct packed {
        logic [10:0] offset;
        logic [7:0]  rbyte;
        logic        pvalid;
        t_info       info;
    } t_fec_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        start_group = 1'b0;
    logic        last_byte = 1'b0;
    logic [15:0] seq_number = '0;
    logic        out_stall = 1'b0;
    wire         in_stall;
    wire         out_valid;
    wire  [10:0] payload_offset;
    wire  [7:0]  recovery_byte;
    wire         payload_valid;
    wire         packet_done;
    wire  [13:0] header_recovery;
    wire  [31:0] timestamp_recovery;
    wire  [15:0] length_recovery;
    wire  [15:0] seqnum_recovery;
    wire  [11:0] recovery_length;
    wire         packet_error;

    t_byte_item  pending_bytes[$];
    t_fec_result expected_results[$];
    t_byte_item  driven_byte;
    bit          hold_next;
    int unsigned n_sent, n_checked, n_packets, n_flagged, n_errors, cycle_count;

    // predictor copy of the group state
    int unsigned grp_pos;
    logic [11:0] grp_len;
    logic [7:0]  parity_mem [0:CAPACITY-1];
    logic [13:0] hdr_par;
    logic [31:0] ts_par;
    logic [15:0] len_par;
    logic [15:0] sn_par;
    logic        ovf_seen;

    rtp_xor_fec_parity_accumulator u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (in_valid),
        .o_stall              (in_stall),
        .i_data_byte          (data_byte),
        .i_start_group        (start_group),
        .i_last_byte          (last_byte),
        .i_seq_number         (seq_number),
        .o_valid              (out_valid),
        .i_stall              (out_stall),
        .o_payload_offset     (payload_offset),
        .o_recovery_byte      (recovery_byte),
        .o_payload_valid      (payload_valid),
        .o_packet_done        (packet_done),
        .o_header_recovery    (header_recovery),
        .o_timestamp_recovery (timestamp_recovery),
        .o_length_recovery    (length_recovery),
        .o_seqnum_recovery    (seqnum_recovery),
        .o_recovery_length    (recovery_length),
        .o_packet_error       (packet_error)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // fold one accepted byte into the group parities, return the expected result
    function automatic t_fec_result fold_packet_byte(t_byte_item it);
        t_fec_result r;
        int unsigned pos, off, plen, kept;
        logic [7:0]  v;
        r = '0;
        if (it.start) begin
            grp_pos  = 0;
            grp_len  = '0;
            hdr_par  = '0;
            ts_par   = '0;
            len_par  = '0;
            sn_par   = '0;
            ovf_seen = 1'b0;
        end
        pos = grp_pos;
        if (pos == POS_HDR_B0) begin
            hdr_par[13:8] ^= it.data[5:0];
        end else if (pos == POS_HDR_B1) begin
            hdr_par[7:0] ^= it.data;
        end else if (pos >= TS_FIRST && pos <= TS_LAST) begin
            ts_par ^= 32'(it.data) << (8 * (TS_LAST - pos));
        end else if (pos >= RTP_HDR_LEN) begin
            off = pos - RTP_HDR_LEN;
            if (off < CAPACITY) begin
                v = it.data;
                if (off < grp_len) v ^= parity_mem[off];
                parity_mem[off] = v;
                r.pvalid = 1'b1;
                r.offset = off[10:0];
                r.rbyte  = v;
            end else begin
                ovf_seen = 1'b1;
            end
        end
        // packet end: fold length and sequence number unless the packet is short
        if (it.last) begin
            if (pos + 1 < RTP_HDR_LEN) begin
                r.info.packet_error = 1'b1;
            end else begin
                plen = pos + 1 - RTP_HDR_LEN;
                kept = (plen > CAPACITY) ? CAPACITY : plen;
                len_par ^= plen[15:0];
                sn_par  ^= it.seq;
                if (kept > grp_len) grp_len = kept[11:0];
                r.info.packet_error = ovf_seen;
            end
            grp_pos  = 0;
            ovf_seen = 1'b0;
        end else if (grp_pos < POS_MAX) begin
            grp_pos++;
        end
        r.info.packet_done        = it.last;
        r.info.header_recovery    = hdr_par;
        r.info.timestamp_recovery = ts_par;
        r.info.length_recovery    = len_par;
        r.info.seqnum_recovery    = sn_par;
        r.info.recovery_length    = grp_len;
        return r;
    endfunction

    // idle mixes rotate with the number of items sent
    function automatic int unsigned sender_idle_pct();
        case ((n_sent / PHASE_LEN) % 4)
            1: return 66;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_stall_pct();
        case ((n_sent / PHASE_LEN) % 4)
            2: return 66;
            3: return 13;
            default: return 0;
        endcase
    endfunction

    // fill = -1 gives random bytes, else every byte and the seq use that value
    task automatic queue_packet(input bit open_group, input int n_bytes, input bit ends,
                                input int fill);
        t_byte_item it;
        for (int k = 0; k < n_bytes; k++) begin
            it.data  = (fill < 0) ? 8'($urandom) : 8'(fill);
            it.start = open_group && (k == 0);
            it.last  = ends && (k == n_bytes - 1);
            it.seq   = (fill < 0) ? 16'($urandom) : {2{8'(fill)}};
            it.hold  = hold_next && (k == 0);
            pending_bytes.push_back(it);
        end
        hold_next = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // driver: hold the item until accepted, then load the next one or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(fold_packet_byte(driven_byte));
                n_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_bytes.size() > 0
                        && $urandom_range(99) >= sender_idle_pct()
                        && !(pending_bytes[0].hold && expected_results.size() > 0)) begin
                    driven_byte = pending_bytes.pop_front();
                    in_valid    <= 1'b1;
                    data_byte   <= driven_byte.data;
                    start_group <= driven_byte.start;
                    last_byte   <= driven_byte.last;
                    seq_number  <= driven_byte.seq;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each accepted result against the oldest prediction
    always @(posedge clk) begin
        t_fec_result exp_r;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: offset %0h byte %0h", payload_offset,
                           recovery_byte);
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    compare_field("payload_offset", 32'(exp_r.offset), 32'(payload_offset));
                    compare_field("recovery_byte", 32'(exp_r.rbyte), 32'(recovery_byte));
                    compare_field("payload_valid", 32'(exp_r.pvalid), 32'(payload_valid));
                    compare_field("packet_done", 32'(exp_r.info.packet_done),
                                  32'(packet_done));
                    compare_field("header_recovery", 32'(exp_r.info.header_recovery),
                                  32'(header_recovery));
                    compare_field("timestamp_recovery", exp_r.info.timestamp_recovery,
                                  timestamp_recovery);
                    compare_field("length_recovery", 32'(exp_r.info.length_recovery),
                                  32'(length_recovery));
                    compare_field("seqnum_recovery", 32'(exp_r.info.seqnum_recovery),
                                  32'(seqnum_recovery));
                    compare_field("recovery_length", 32'(exp_r.info.recovery_length),
                                  32'(recovery_length));
                    compare_field("packet_error", 32'(exp_r.info.packet_error),
                                  32'(packet_error));
                    if (exp_r.info.packet_done) n_packets++;
                    if (exp_r.info.packet_error) n_flagged++;
                    n_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
                   expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned base, pick, n_pkts;
        bit          paused;
        paused    = 1'b0;
        hold_next = 1'b0;
        grp_pos   = 0;
        grp_len   = '0;
        hdr_par   = '0;
        ts_par    = '0;
        len_par   = '0;
        sn_par    = '0;
        ovf_seen  = 1'b0;
        for (int k = 0; k < CAPACITY; k++) parity_mem[k] = '0;

        // directed: field extremes, short packets, restart mid-packet
        queue_packet(1, RTP_HDR_LEN + 1, 1, 8'hFF);
        queue_packet(0, RTP_HDR_LEN + 2, 1, 8'h00);
        queue_packet(0, 5, 1, -1);
        queue_packet(0, 1, 1, -1);
        queue_packet(0, 8, 0, -1);
        queue_packet(1, RTP_HDR_LEN + 3, 1, -1);
        // a longer packet in the same group: XOR over the stored part, rest as is
        queue_packet(0, RTP_HDR_LEN + 4, 1, -1);

        // random: mostly well-formed groups, some short, cut and ungrouped packets
        hold_next = 1'b1;
        base = pending_bytes.size();
        while (pending_bytes.size() < base + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                n_pkts = $urandom_range(1, 5);
                for (int p = 0; p < n_pkts; p++)
                    queue_packet(p == 0, RTP_HDR_LEN + (($urandom_range(19) == 0) ?
                                 $urandom_range(300) : $urandom_range(40)), 1, -1);
            end else if (pick < 80) begin
                queue_packet(1'($urandom_range(1)), $urandom_range(1, RTP_HDR_LEN - 1),
                             1, -1);
            end else if (pick < 90) begin
                queue_packet(0, $urandom_range(1, 30), 0, -1);
            end else begin
                queue_packet(0, RTP_HDR_LEN + $urandom_range(40), 1, -1);
            end
            if (!paused && pending_bytes.size() > base + RANDOM_ITEMS / 2) begin
                hold_next = 1'b1;
                paused    = 1'b1;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d results over %0d packets (%0d flagged as errors),", n_checked,
                 n_packets, n_flagged);
        $display("covering short, cut and restarted packets under four idle mixes.");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
